[rtl/core/gbd_pkg.sv]
// Shared status type and status codes for the Golomb bit decoder.
`timescale 1ns / 1ps
`default_nettype none

package gbd_pkg;

    // Result status carried with every decoded result.
    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_CUT   = 2'd1;
    localparam status_t STATUS_LARGE = 2'd2;

endpackage

`default_nettype wire

[rtl/core/golomb_bit_decoder.sv]
// Golomb bit decoder: one code bit per request in, one signed value per codeword out.
//
// The decoder takes one code bit, or an end-of-stream mark, in every cycle that
// in_stall is low and updates its codeword parser at that edge. The rate is one
// request per cycle while the output is not stalled, set by the parser update (one
// add and compare on the scaled quotient). A finished codeword is registered in a
// two-entry result buffer ahead of the output, so in_stall is a register and rises
// only after the output was stalled with a result waiting. The user must write the
// divisor register through cfg_wr_en and cfg_wr_data only while the decoder is idle;
// the block does not enforce it. Status 1 marks a codeword cut short by the end of
// stream, status 2 a value beyond the output range, both with value 0.
`timescale 1ns / 1ps
`default_nettype none

module golomb_bit_decoder #(
    parameter int VALUE_BITS   = 32,
    parameter int DIVISOR_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [DIVISOR_BITS-1:0]     cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        code_bit,
    input  wire logic                        stream_end,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [VALUE_BITS-1:0]     decoded_value,
    output gbd_pkg::status_t                 status
);
    import gbd_pkg::*;

    localparam int B_W = $clog2(DIVISOR_BITS + 1);

    logic                    in_accept;
    logic [DIVISOR_BITS-1:0] m_eff;
    logic                    m_is_one;
    logic [B_W-1:0]          b_len;
    logic [DIVISOR_BITS-1:0] t_thresh;
    logic                    res_valid;
    logic [VALUE_BITS-1:0]   res_value;
    status_t                 res_status;
    logic [VALUE_BITS-1:0]   out_value;
    logic                    buf_full;

    assign in_accept = in_valid && !in_stall;

    // Divisor and its derived code lengths.
    gbd_divisor #(
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_divisor (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_eff       (m_eff),
        .m_is_one    (m_is_one),
        .b_len       (b_len),
        .t_thresh    (t_thresh)
    );

    // Codeword parser.
    gbd_parser #(
        .VALUE_BITS   (VALUE_BITS),
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_accept),
        .code_bit   (code_bit),
        .stream_end (stream_end),
        .m_eff      (m_eff),
        .m_is_one   (m_is_one),
        .b_len      (b_len),
        .t_thresh   (t_thresh),
        .res_valid  (res_valid),
        .res_value  (res_value),
        .res_status (res_status)
    );

    // Result register and skid stage.
    gbd_out_buf #(
        .VALUE_BITS (VALUE_BITS)
    ) u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (res_valid),
        .push_value  (res_value),
        .push_status (res_status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_value   (out_value),
        .out_status  (status),
        .full        (buf_full)
    );

    assign in_stall      = buf_full;
    assign decoded_value = $signed(out_value);

`ifndef SYNTH
    // A full skid stage always sits behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("skid stage full without a result in the output register");

    // The input side stalls only after a result was held at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall rose without a stalled result");

    // Error results carry a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> (decoded_value == '0))
        else $error("nonzero value with an error status");

    // Only the three defined status codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_CUT ||
                       status == STATUS_LARGE))
        else $error("undefined status code on the output");
`endif

endmodule

`default_nettype wire

[rtl/core/gbd_divisor.sv]
// Divisor register and the code lengths derived from it.
`timescale 1ns / 1ps
`default_nettype none

module gbd_divisor #(
    parameter int DIVISOR_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [DIVISOR_BITS-1:0]               cfg_wr_data,
    output logic      [DIVISOR_BITS-1:0]               m_eff,
    output logic                                       m_is_one,
    output logic      [$clog2(DIVISOR_BITS + 1)-1:0]   b_len,
    output logic      [DIVISOR_BITS-1:0]               t_thresh
);
    localparam int B_W = $clog2(DIVISOR_BITS + 1);

    logic [DIVISOR_BITS-1:0] divisor_reg;
    logic [DIVISOR_BITS-1:0] m_minus_one;
    logic [DIVISOR_BITS:0]   pow_b;

    // The divisor register, reset to four.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= DIVISOR_BITS'(4);
        end
        else if (cfg_wr_en)
        begin
            divisor_reg <= cfg_wr_data;
        end
    end

    // A divisor of zero behaves as a divisor of one.
    assign m_eff       = (divisor_reg == '0) ? DIVISOR_BITS'(1) : divisor_reg;
    assign m_is_one    = (m_eff == DIVISOR_BITS'(1));
    assign m_minus_one = m_eff - DIVISOR_BITS'(1);

    // Ceiling of log2 of m is the length of m - 1 in bits.
    always_comb
    begin
        b_len = '0;
        for (int i = 0; i < DIVISOR_BITS; i++)
        begin
            if (m_minus_one[i])
            begin
                b_len = B_W'(i + 1);
            end
        end
    end

    // Threshold of the truncated binary code: 2^b - m, always below m.
    assign pow_b    = (DIVISOR_BITS + 1)'(1) << b_len;
    assign t_thresh = DIVISOR_BITS'(pow_b - (DIVISOR_BITS + 1)'(m_eff));

endmodule

`default_nettype wire

[rtl/core/gbd_parser.sv]
// Codeword parser: unary quotient, truncated binary remainder and unmapping.
`timescale 1ns / 1ps
`default_nettype none

module gbd_parser #(
    parameter int VALUE_BITS   = 32,
    parameter int DIVISOR_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  step,
    input  wire logic                                  code_bit,
    input  wire logic                                  stream_end,
    input  wire logic [DIVISOR_BITS-1:0]               m_eff,
    input  wire logic                                  m_is_one,
    input  wire logic [$clog2(DIVISOR_BITS + 1)-1:0]   b_len,
    input  wire logic [DIVISOR_BITS-1:0]               t_thresh,
    output logic                                       res_valid,
    output logic      [VALUE_BITS-1:0]                 res_value,
    output gbd_pkg::status_t                           res_status
);
    import gbd_pkg::*;

    localparam int BR_W  = $clog2(DIVISOR_BITS + 1);
    localparam int SUM_W = ((VALUE_BITS > DIVISOR_BITS) ? VALUE_BITS : DIVISOR_BITS) + 2;
    localparam logic [SUM_W-1:0] LIMIT =
        (SUM_W'(1) << VALUE_BITS) - SUM_W'(1);
    localparam logic [VALUE_BITS:0] SQ_SAT = (VALUE_BITS + 1)'(1) << VALUE_BITS;

    typedef enum logic [1:0] {
        PH_UNARY = 2'd0,
        PH_BITS  = 2'd1,
        PH_EXTRA = 2'd2
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [VALUE_BITS:0]     sq_reg, sq_next;
    logic [DIVISOR_BITS-1:0] rc_reg, rc_next;
    logic [BR_W-1:0]         br_reg, br_next;
    logic                    too_large_reg, too_large_next;

    logic [DIVISOR_BITS-1:0] rc_shift;
    logic [DIVISOR_BITS:0]   code_ext;
    logic [DIVISOR_BITS:0]   t_ext;
    logic [BR_W-1:0]         br_dec;
    logic [BR_W-1:0]         b_minus_one;
    logic [SUM_W-1:0]        unary_sum;
    logic                    do_finish;
    logic                    do_cut;
    logic [DIVISOR_BITS:0]   fin_r;
    logic [SUM_W-1:0]        fin_sum;
    logic                    fin_large;
    logic [VALUE_BITS-1:0]   fin_half;

    // Per-bit helpers for the remainder and the quotient.
    assign code_ext    = {rc_reg, code_bit};
    assign rc_shift    = DIVISOR_BITS'(code_ext);
    assign t_ext       = {1'b0, t_thresh};
    assign br_dec      = (br_reg != '0) ? br_reg - BR_W'(1) : '0;
    assign b_minus_one = b_len - BR_W'(1);
    assign unary_sum   = SUM_W'(sq_reg) + SUM_W'(m_eff);

    // Next state of the parser for one accepted request.
    always_comb
    begin
        phase_next     = phase_reg;
        sq_next        = sq_reg;
        rc_next        = rc_reg;
        br_next        = br_reg;
        too_large_next = too_large_reg;
        do_finish      = 1'b0;
        do_cut         = 1'b0;
        fin_r          = '0;
        if (step)
        begin
            if (stream_end)
            begin
                do_cut         = (phase_reg inside {PH_BITS, PH_EXTRA});
                phase_next     = PH_UNARY;
                sq_next        = '0;
                rc_next        = '0;
                br_next        = '0;
                too_large_next = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_BITS:
                    begin
                        rc_next = rc_shift;
                        br_next = br_dec;
                        if (br_dec == '0)
                        begin
                            if (rc_shift >= t_thresh)
                            begin
                                phase_next = PH_EXTRA;
                            end
                            else
                            begin
                                do_finish = 1'b1;
                                fin_r     = {1'b0, rc_shift};
                            end
                        end
                    end
                    PH_EXTRA:
                    begin
                        do_finish = 1'b1;
                        fin_r     = (code_ext >= t_ext) ? code_ext - t_ext : '0;
                    end
                    default:
                    begin
                        // Unary part; the unused phase code lands here as well.
                        if (!code_bit)
                        begin
                            if (!too_large_reg)
                            begin
                                if (unary_sum > LIMIT)
                                begin
                                    too_large_next = 1'b1;
                                    sq_next        = SQ_SAT;
                                end
                                else
                                begin
                                    sq_next = unary_sum[VALUE_BITS:0];
                                end
                            end
                        end
                        else if (m_is_one)
                        begin
                            do_finish = 1'b1;
                        end
                        else
                        begin
                            rc_next = '0;
                            br_next = b_minus_one;
                            if (b_minus_one != '0)
                            begin
                                phase_next = PH_BITS;
                            end
                            else if (t_thresh == '0)
                            begin
                                phase_next = PH_EXTRA;
                            end
                            else
                            begin
                                do_finish = 1'b1;
                            end
                        end
                    end
                endcase
                if (do_finish)
                begin
                    phase_next     = PH_UNARY;
                    sq_next        = '0;
                    rc_next        = '0;
                    br_next        = '0;
                    too_large_next = 1'b0;
                end
            end
        end
    end

    // Mapped value m*q + r, range check and zigzag unmapping.
    assign fin_sum   = SUM_W'(sq_reg) + SUM_W'(fin_r);
    assign fin_large = too_large_reg || (fin_sum > LIMIT);
    assign fin_half  = fin_sum[VALUE_BITS:1];

    always_comb
    begin
        res_valid  = do_finish || do_cut;
        res_value  = '0;
        res_status = STATUS_OK;
        if (do_cut)
        begin
            res_status = STATUS_CUT;
        end
        else if (fin_large)
        begin
            res_status = STATUS_LARGE;
        end
        else
        begin
            res_value = fin_sum[0] ? ~fin_half : fin_half;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_UNARY;
            sq_reg        <= '0;
            rc_reg        <= '0;
            br_reg        <= '0;
            too_large_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sq_reg        <= sq_next;
            rc_reg        <= rc_next;
            br_reg        <= br_next;
            too_large_reg <= too_large_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/gbd_out_buf.sv]
// Result register with a skid stage so that input stall is registered.
`timescale 1ns / 1ps
`default_nettype none

module gbd_out_buf #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire logic [VALUE_BITS-1:0]     push_value,
    input  wire gbd_pkg::status_t          push_status,
    input  wire logic                      out_stall,
    output logic                           out_valid,
    output logic      [VALUE_BITS-1:0]     out_value,
    output gbd_pkg::status_t               out_status,
    output logic                           full
);
    import gbd_pkg::*;

    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    status_t               out_status_reg, out_status_next;
    logic [VALUE_BITS-1:0] skid_value_reg, skid_value_next;
    status_t               skid_status_reg, skid_status_next;
    logic                  out_free;

    // The result register is free when empty or taken at this edge.
    assign out_free = !out_valid_reg || !out_stall;

    // Refill from the skid stage first, else from the parser.
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_value_next  = skid_value_reg;
        skid_status_next = skid_status_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_value_next  = skid_value_reg;
                out_status_next = skid_status_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_valid_next  = 1'b1;
                out_value_next  = push_value;
                out_status_next = push_status;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_valid_next  = 1'b1;
            skid_value_next  = push_value;
            skid_status_next = push_status;
        end
    end

    // Occupancy flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
        skid_value_reg  <= skid_value_next;
        skid_status_reg <= skid_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign full       = skid_valid_reg;

endmodule

`default_nettype wire
